[rtl/core/sdpm_pkg.sv]
// Shared constants for the stick dead zone pointer mover.
// Scaling constants, register indexes and field widths; no dependencies.
package sdpm_pkg;

    // Scale of one raw axis sample; the dead zone is measured against it.
    localparam int AXIS_FULL_SCALE = 32768;
    // Sub-pixel units per whole pixel; must be a power of two.
    localparam int MOTION_DIVISOR  = 4096;
    localparam int MOTION_SHIFT    = $clog2(MOTION_DIVISOR);

    // Largest scaled axis value.
    localparam int Q_LIMIT = 262144;

    localparam int AXIS_W  = 16;
    localparam int ACC_W   = 17;
    localparam int REL_W   = 5;
    localparam int DZ_W    = 15;
    localparam int SCALE_W = 20;
    localparam int Q_W     = 20;

    localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 15'd3000;
    localparam logic            IN_MENU_RESET   = 1'b1;

    // Configuration register indexes
    localparam logic REG_DEAD_ZONE = 1'b0;
    localparam logic REG_IN_MENU   = 1'b1;

endpackage

[rtl/core/stick_deadzone_pointer_mover_top.sv]
// Radial scaled dead zone for an analog stick, driving a pointer position.
// One shared multiplier and one shared subtractor under a sequencer.
// Depends on sdpm_pkg.
//
//  channel   direction  fields
//  -------   ---------  ----------------------------------------------------
//  s_axis    in         tuser: mode; tdata: stick_x, stick_y, set_pointer_x/y
//  m_axis    out        tuser: moved, warp; tdata: pointer_x/y, rel_x/y
//  cfg       in         index 0 dead_zone, index 1 in_menu
//
// Outside the dead zone a stick sample goes from input beat to loaded result
// through two squarings, 16 square root steps, a check, one denominator multiply,
// and per axis two multiplies, a range check and a 20 step restoring divide; the
// root, range checks and divides use the shared subtractor. Inside the dead zone
// it skips scaling and a set-position beat goes straight to the result; the next
// beat can be taken the cycle after the result is loaded. Synchronous active-low
// reset loads dead_zone 3000, in_menu 1 and clears accumulators and position.
// Input and configuration beats are taken only when the sequencer is idle, and
// configuration only while no input beat is offered; a finished result waits in
// the output register; the block stalls at the end of the next item if still full.
module stick_deadzone_pointer_mover_top
    import sdpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [15:0] stick_x, [31:16] stick_y,
                                     // [47:32] set_pointer_x, [63:48] set_pointer_y
    input  logic        i_s_tuser,   // [0] mode
    // m_axis
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [15:0] pointer_x, [31:16] pointer_y,
                                     // [36:32] rel_x, [41:37] rel_y, [47:42] zero
    output logic [1:0]  o_m_tuser,   // [0] moved, [1] warp
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQX   = 4'd1;
    localparam logic [3:0] S_SQY   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_DEN   = 4'd5;
    localparam logic [3:0] S_NUM1  = 4'd6;
    localparam logic [3:0] S_NUM2  = 4'd7;
    localparam logic [3:0] S_PRE   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_STORE = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_MOVE  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    localparam int SUB_W = 52;

    localparam logic [15:0] FS16 = 16'(AXIS_FULL_SCALE);

    // Control and state
    logic [3:0]              r_state;
    logic [DZ_W-1:0]         r_dead_zone;
    logic                    r_in_menu;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;
    logic signed [15:0]      r_pos_x, r_pos_y;
    logic                    r_out_valid;
    logic [4:0]              r_cnt;
    logic                    r_axis;

    // Datapath payload
    logic [15:0]               r_ax, r_ay;
    logic                      r_negx, r_negy;
    logic [31:0]               r_n, r_res, r_bit, r_den;
    logic [47:0]               r_num;
    logic [50:0]               r_div;
    logic [Q_W-1:0]            r_q;
    logic                      r_ovf;
    logic signed [SCALE_W-1:0] r_sx, r_sy;
    logic                      r_moved;
    logic [REL_W-1:0]          r_rel_x, r_rel_y;
    logic [47:0]               r_out_tdata;
    logic [1:0]                r_out_tuser;

    // Shared units
    logic [31:0]      mul_a;
    logic [15:0]      mul_b;
    logic [47:0]      mul_p;
    logic [SUB_W-1:0] sub_a, sub_b;
    logic [SUB_W:0]   sub_diff;
    logic             sub_ge;

    logic [15:0] m_val, m_minus_d, ax_in, ay_in;
    logic        zero_scale;
    logic [18:0] q_clamped;
    logic [SCALE_W-1:0] scaled;

    logic signed [20:0] sum_x, sum_y;
    logic signed [ACC_W-1:0] sat_x, sat_y;
    logic signed [17:0] bias_x, bias_y, rel_fx, rel_fy, rem_x, rem_y;
    logic signed [18:0] pos_sx, pos_sy;
    logic signed [15:0] sat_px, sat_py;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [20:0] v);
        if (v > 21'sd65535) begin
            sat_acc = 17'sd65535;
        end else if (v < -21'sd65536) begin
            sat_acc = -17'sd65536;
        end else begin
            sat_acc = v[ACC_W-1:0];
        end
    endfunction

    function automatic logic signed [15:0] sat_pos(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            sat_pos = 16'sd32767;
        end else if (v < -19'sd32768) begin
            sat_pos = -16'sd32768;
        end else begin
            sat_pos = v[15:0];
        end
    endfunction

    assign ax_in = i_s_tdata[15] ? 16'(~i_s_tdata[15:0] + 16'd1) : i_s_tdata[15:0];
    assign ay_in = i_s_tdata[31] ? 16'(~i_s_tdata[31:16] + 16'd1) : i_s_tdata[31:16];

    assign m_val      = r_res[15:0];
    assign m_minus_d  = m_val - {1'b0, r_dead_zone};
    assign zero_scale = (m_val == 16'd0) || (m_val < {1'b0, r_dead_zone})
                        || ({1'b0, r_dead_zone} >= FS16);

    always_comb begin
        mul_a = {16'd0, r_ax};
        mul_b = r_ax;
        case (r_state)
            S_SQX: begin
                mul_a = {16'd0, r_ax};
                mul_b = r_ax;
            end
            S_SQY: begin
                mul_a = {16'd0, r_ay};
                mul_b = r_ay;
            end
            S_DEN: begin
                mul_a = {16'd0, m_val};
                mul_b = FS16 - {1'b0, r_dead_zone};
            end
            S_NUM1: begin
                mul_a = {16'd0, (r_axis ? r_ay : r_ax)};
                mul_b = m_minus_d;
            end
            S_NUM2: begin
                mul_a = r_num[31:0];
                mul_b = FS16;
            end
            default: begin
                mul_a = {16'd0, r_ax};
                mul_b = r_ax;
            end
        endcase
    end

    assign mul_p = 48'(mul_a) * 48'(mul_b);

    always_comb begin
        sub_a = SUB_W'(r_num);
        sub_b = {1'b0, r_div};
        case (r_state)
            S_SQRT: begin
                sub_a = SUB_W'(r_n);
                sub_b = SUB_W'(r_res + r_bit);
            end
            S_PRE: begin
                sub_a = SUB_W'(r_num);
                sub_b = {r_den, 20'd0};
            end
            default: begin
                sub_a = SUB_W'(r_num);
                sub_b = {1'b0, r_div};
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[SUB_W];

    assign q_clamped = (r_ovf || (r_q > Q_W'(Q_LIMIT))) ? 19'(Q_LIMIT) : r_q[18:0];
    assign scaled    = (r_axis ? r_negy : r_negx) ? SCALE_W'(20'd0 - {1'b0, q_clamped})
                                                  : {1'b0, q_clamped};

    assign sum_x = 21'(r_acc_x) + 21'(r_sx);
    assign sum_y = 21'(r_acc_y) + 21'(r_sy);
    assign sat_x = sat_acc(sum_x);
    assign sat_y = sat_acc(sum_y);

    // Truncate toward zero: bias negatives by divisor minus one before the shift
    assign bias_x = 18'(r_acc_x) + (r_acc_x[ACC_W-1] ? 18'(MOTION_DIVISOR - 1) : 18'sd0);
    assign bias_y = 18'(r_acc_y) + (r_acc_y[ACC_W-1] ? 18'(MOTION_DIVISOR - 1) : 18'sd0);
    assign rel_fx = bias_x >>> MOTION_SHIFT;
    assign rel_fy = bias_y >>> MOTION_SHIFT;
    assign rem_x  = 18'(r_acc_x) - (rel_fx <<< MOTION_SHIFT);
    assign rem_y  = 18'(r_acc_y) - (rel_fy <<< MOTION_SHIFT);
    assign pos_sx = 19'(r_pos_x) + 19'(rel_fx);
    assign pos_sy = 19'(r_pos_y) + 19'(rel_fy);
    assign sat_px = sat_pos(pos_sx);
    assign sat_py = sat_pos(pos_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dead_zone <= DEAD_ZONE_RESET;
            r_in_menu   <= IN_MENU_RESET;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_axis      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_DEAD_ZONE: r_dead_zone <= i_cfg_data;
                    REG_IN_MENU:   r_in_menu   <= i_cfg_data[0];
                    default:       r_dead_zone <= r_dead_zone;
                endcase
            end

            // Load on a finished item, otherwise drop the beat once taken
            if ((r_state == S_DONE) && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_moved <= 1'b0;
                        r_rel_x <= '0;
                        r_rel_y <= '0;
                        r_ax    <= ax_in;
                        r_ay    <= ay_in;
                        r_negx  <= i_s_tdata[15];
                        r_negy  <= i_s_tdata[31];
                        r_axis  <= 1'b0;
                        if (i_s_tuser) begin
                            r_pos_x <= i_s_tdata[47:32];
                            r_pos_y <= i_s_tdata[63:48];
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SQX;
                        end
                    end
                end
                S_SQX: begin
                    r_n     <= mul_p[31:0];
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_n     <= r_n + mul_p[31:0];
                    r_res   <= '0;
                    r_bit   <= 32'h4000_0000;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sub_ge) begin
                        r_n   <= sub_diff[31:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 32'd1) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (zero_scale) begin
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_den   <= mul_p[31:0];
                    r_state <= S_NUM1;
                end
                S_NUM1: begin
                    r_num   <= mul_p;
                    r_state <= S_NUM2;
                end
                S_NUM2: begin
                    r_num   <= mul_p;
                    r_state <= S_PRE;
                end
                S_PRE: begin
                    // Quotient too large for 20 bits: flag it so the result is clamped
                    r_ovf   <= sub_ge;
                    r_div   <= {r_den, 19'd0};
                    r_q     <= '0;
                    r_cnt   <= 5'd19;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (sub_ge) begin
                        r_num <= sub_diff[47:0];
                    end
                    r_q   <= {r_q[Q_W-2:0], sub_ge};
                    r_div <= r_div >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (r_axis) begin
                        r_sy    <= scaled;
                        r_state <= S_ACC;
                    end else begin
                        r_sx    <= scaled;
                        r_axis  <= 1'b1;
                        r_state <= S_NUM1;
                    end
                end
                S_ACC: begin
                    r_acc_x <= sat_x;
                    r_acc_y <= sat_y;
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    if ((r_acc_x != '0) || (r_acc_y != '0)) begin
                        r_moved <= 1'b1;
                        r_rel_x <= rel_fx[REL_W-1:0];
                        r_rel_y <= rel_fy[REL_W-1:0];
                        r_acc_x <= rem_x[ACC_W-1:0];
                        r_acc_y <= rem_y[ACC_W-1:0];
                        r_pos_x <= sat_px;
                        r_pos_y <= sat_py;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free or being drained
                    if (!r_out_valid || i_m_tready) begin
                        r_out_tdata <= {6'd0, r_rel_y, r_rel_x, r_pos_y, r_pos_x};
                        r_out_tuser <= {r_in_menu, r_moved};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_tdata;
    assign o_m_tuser   = r_out_tuser;
    // Take register writes only between items
    assign o_cfg_ready = (r_state == S_IDLE) && !i_s_tvalid;

    // An accepted beat makes the sequencer busy on the next cycle
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready
    ) else $error("input still ready after accepting a beat");

    // No move means no step
    a_no_move_no_rel: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata[41:32] == 10'd0)
    ) else $error("step reported without a move");

    // After a move only a sub-pixel remainder is left
    a_remainder_small: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_MOVE) |->
            (r_acc_x > -17'(MOTION_DIVISOR)) && (r_acc_x < 17'(MOTION_DIVISOR)) &&
            (r_acc_y > -17'(MOTION_DIVISOR)) && (r_acc_y < 17'(MOTION_DIVISOR))
    ) else $error("accumulator remainder out of range");

endmodule
